@@ design/fcs_pkg.sv @@
package fcs_pkg;

	// Request and result payloads.
	typedef struct packed {
		logic [31:0] target_freq;
		logic [31:0] current_freq;
	} req_t;

	typedef struct packed {
		logic        bad_request;
		logic        improved;
		logic        target_hit;
		logic [1:0]  src_sel;
		logic [2:0]  div_sel;
		logic        exact_sel;
		logic [1:0]  rng_sel;
		logic [31:0] out_freq;
	} rsp_t;

	// One candidate configuration as it enters the minimum search.
	typedef struct packed {
		logic        valid;
		logic        improved;
		logic [31:0] gap;
		logic [31:0] freq;
		logic [1:0]  src;
		logic [2:0]  div;
		logic        exact;
		logic [1:0]  rng;
	} cand_t;

	localparam int N_LEAF = 16;
	localparam int N_IN   = 3;

	localparam logic [31:0] WIN_MIN   = 32'd31250;
	localparam logic [31:0] WIN_MAX   = 32'd39062;
	localparam logic [19:0] REF_LO    = 20'd32767;
	localparam logic [19:0] REF_HI    = 20'd32769;
	localparam logic [31:0] LOW_SPLIT = 32'd32786;

	localparam logic [31:0] RNG0_MIN = 32'd20000000;
	localparam logic [31:0] RNG0_MAX = 32'd25000000;
	localparam logic [31:0] RNG1_MIN = 32'd40000000;
	localparam logic [31:0] RNG1_MAX = 32'd50000000;
	localparam logic [31:0] RNG2_MIN = 32'd60000000;
	localparam logic [31:0] RNG2_MAX = 32'd75000000;
	localparam logic [31:0] RNG3_MIN = 32'd80000000;
	localparam logic [31:0] RNG3_MAX = 32'd100000000;

	// Reciprocals for division by 5 and by 3 of a 32-bit value.
	localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;
	localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

	localparam logic [1:0] SRC_OSC0 = 2'd0;
	localparam logic [1:0] SRC_IRC  = 2'd2;
	localparam logic [2:0] DIV_IRC  = 3'd1;

	localparam logic CFG_IRC  = 1'b0;
	localparam logic CFG_OSC0 = 1'b1;

	// FLL multiplication factor of each range.
	function automatic logic [11:0] rng_fac(input logic [1:0] r);
		logic [11:0] f;
		case (r)
			2'd0: f = 12'd640;
			2'd1: f = 12'd1280;
			2'd2: f = 12'd1920;
			2'd3: f = 12'd2560;
			default: f = 12'd640;
		endcase
		return f;
	endfunction

	// Output frequency of each range in exact-reference mode.
	function automatic logic [31:0] rng_ref(input logic [1:0] r);
		logic [31:0] f;
		case (r)
			2'd0: f = 32'd24000000;
			2'd1: f = 32'd48000000;
			2'd2: f = 32'd72000000;
			2'd3: f = 32'd96000000;
			default: f = 32'd24000000;
		endcase
		return f;
	endfunction

	function automatic logic [31:0] absdiff(input logic [31:0] a, input logic [31:0] b);
		return (a < b) ? (b - a) : (a - b);
	endfunction

	// A valid right candidate wins if the left is invalid or strictly farther; the earlier one keeps ties.
	function automatic cand_t pick(input cand_t a, input cand_t b);
		if (b.valid && (!a.valid || (b.gap < a.gap)))
			return b;
		return a;
	endfunction

endpackage

@@ design/fcs_min_tree.sv @@
module fcs_min_tree
	import fcs_pkg::*;
(
	input  logic  clk,
	input  cand_t leaf [N_LEAF],
	output cand_t win_s5
);

	cand_t quad_s4 [4];

	// First stage: each group of four leaves reduces to one.
	always_ff @(posedge clk) begin
		for (int g = 0; g < 4; g++) begin
			quad_s4[g] <= pick(pick(leaf[4*g], leaf[4*g+1]),
				pick(leaf[4*g+2], leaf[4*g+3]));
		end
	end

	// Second stage: the four group winners reduce to the final one.
	always_ff @(posedge clk) begin
		win_s5 <= pick(pick(quad_s4[0], quad_s4[1]), pick(quad_s4[2], quad_s4[3]));
	end

endmodule

@@ design/fll_clock_config_search.sv @@
// FLL clock configuration search.
// A request (target and current best frequency) is taken at a rising edge with
// start high and busy low. busy is always low, so a request may come every cycle.
// Each request gives exactly one result on rsp, marked by done for one cycle;
// results leave in request order. The pipeline has five register stages: range
// choice and the reciprocal multiplies for the dividers 1280 and 1536, divider
// selection, the FLL products, the first level of the closest-candidate search,
// and the last. The receiver cannot hold results off and the pipeline never
// stalls. Configuration (cfg_we, cfg_idx, cfg_wdata) is to be written by the
// user only while no request is in flight; the block does not enforce it.
// Index 0 is the slow internal clock frequency, index 1 the oscillator 0
// frequency. Reset sets them to 32768 Hz and 0 Hz and empties the pipeline;
// no result is produced for a request lost to reset.
module fll_clock_config_search
	import fcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata
);

	logic [19:0] irc_q;
	logic [31:0] osc0_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irc_q  <= 20'd32768;
			osc0_q <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_IRC:  irc_q  <= cfg_wdata[19:0];
				CFG_OSC0: osc0_q <= cfg_wdata;
				default:  ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: range choice and reciprocal multiplies.
	logic [31:0] tgt_s1, cur_s1, osc_s1;
	logic [19:0] irc_s1;
	logic [1:0]  r0_s1, r1_s1;
	logic        two_s1;
	logic [55:0] m5_s1;
	logic [54:0] m3_s1;
	logic [1:0]  r0_d, r1_d;
	logic        two_d;
	logic [31:0] t;

	always_comb begin
		t     = req.target_freq;
		r0_d  = 2'd0;
		r1_d  = 2'd0;
		two_d = 1'b0;
		if (t <= RNG0_MIN)      r0_d = 2'd0;
		else if (t >= RNG3_MAX) r0_d = 2'd3;
		else if (t <= RNG0_MAX) r0_d = 2'd0;
		else if (t < RNG1_MIN) begin
			r0_d = 2'd0; r1_d = 2'd1; two_d = 1'b1;
		end else if (t <= RNG1_MAX) r0_d = 2'd1;
		else if (t < RNG2_MIN) begin
			r0_d = 2'd1; r1_d = 2'd2; two_d = 1'b1;
		end else if (t <= RNG2_MAX) r0_d = 2'd2;
		else if (t < RNG3_MIN) begin
			r0_d = 2'd2; r1_d = 2'd3; two_d = 1'b1;
		end else r0_d = 2'd3;
	end

	always_ff @(posedge clk) begin
		tgt_s1 <= req.target_freq;
		cur_s1 <= req.current_freq;
		osc_s1 <= osc0_q;
		irc_s1 <= irc_q;
		r0_s1  <= r0_d;
		r1_s1  <= r1_d;
		two_s1 <= two_d;
		m5_s1  <= osc0_q[31:8] * RECIP5;
		m3_s1  <= osc0_q[31:9] * RECIP3;
	end

	// Stage 2: FLL input frequencies from each source.
	logic [31:0] tgt_s2, cur_s2;
	logic [1:0]  r0_s2, r1_s2;
	logic        two_s2;
	logic [19:0] f_s2 [N_IN];
	logic [2:0]  id_s2 [N_IN];
	logic        fv_s2 [N_IN];
	logic [31:0] q [8];
	logic [7:0]  fit;
	logic [15:0] hf [2];
	logic [2:0]  hid [2];
	logic        hv [2];
	logic [1:0]  cnt;
	logic        hi_path, lo_fit;

	always_comb begin
		for (int k = 0; k < 6; k++) q[k] = osc_s1 >> (5 + k);
		q[6] = {10'd0, m5_s1[55:34]};
		q[7] = {10'd0, m3_s1[54:33]};
		for (int k = 0; k < 8; k++) fit[k] = (q[k] >= WIN_MIN) && (q[k] <= WIN_MAX);
		hi_path = osc_s1 >= LOW_SPLIT;
		lo_fit  = (osc_s1 > WIN_MIN) && (osc_s1 < LOW_SPLIT);
		cnt = 2'd0;
		for (int s = 0; s < 2; s++) begin
			hf[s] = 16'd0; hid[s] = 3'd0; hv[s] = 1'b0;
		end
		// Keep the first two dividers whose quotient lands in the window.
		for (int k = 0; k < 8; k++) begin
			if (fit[k] && cnt == 2'd0) begin
				hf[0] = q[k][15:0]; hid[0] = 3'(k); hv[0] = 1'b1; cnt = 2'd1;
			end else if (fit[k] && cnt == 2'd1) begin
				hf[1] = q[k][15:0]; hid[1] = 3'(k); hv[1] = 1'b1; cnt = 2'd2;
			end
		end
	end

	always_ff @(posedge clk) begin
		tgt_s2   <= tgt_s1;
		cur_s2   <= cur_s1;
		r0_s2    <= r0_s1;
		r1_s2    <= r1_s1;
		two_s2   <= two_s1;
		f_s2[0]  <= irc_s1;
		id_s2[0] <= DIV_IRC;
		fv_s2[0] <= 1'b1;
		if (hi_path) begin
			f_s2[1] <= {4'd0, hf[0]}; id_s2[1] <= hid[0]; fv_s2[1] <= hv[0];
			f_s2[2] <= {4'd0, hf[1]}; id_s2[2] <= hid[1]; fv_s2[2] <= hv[1];
		end else begin
			f_s2[1] <= {4'd0, osc_s1[15:0]}; id_s2[1] <= 3'd0; fv_s2[1] <= lo_fit;
			f_s2[2] <= 20'd0;                id_s2[2] <= 3'd0; fv_s2[2] <= 1'b0;
		end
	end

	// Stage 3: standard FLL products for each input and range.
	logic [31:0] tgt_s3, cur_s3;
	logic [1:0]  r0_s3, r1_s3;
	logic        two_s3;
	logic [31:0] prod_s3 [N_IN][2];
	logic [2:0]  id_s3 [N_IN];
	logic        fv_s3 [N_IN];
	logic        near_s3 [N_IN];

	always_ff @(posedge clk) begin
		tgt_s3 <= tgt_s2;
		cur_s3 <= cur_s2;
		r0_s3  <= r0_s2;
		r1_s3  <= r1_s2;
		two_s3 <= two_s2;
		for (int d = 0; d < N_IN; d++) begin
			prod_s3[d][0] <= {12'd0, f_s2[d]} * {20'd0, rng_fac(r0_s2)};
			prod_s3[d][1] <= {12'd0, f_s2[d]} * {20'd0, rng_fac(r1_s2)};
			id_s3[d]      <= id_s2[d];
			fv_s3[d]      <= fv_s2[d];
			near_s3[d]    <= (f_s2[d] >= REF_LO) && (f_s2[d] <= REF_HI);
		end
	end

	// Candidate list in evaluation order; the current configuration comes first.
	cand_t leaf [N_LEAF];
	always_comb begin
		for (int n = 0; n < N_LEAF; n++) leaf[n] = '0;
		leaf[0].valid = 1'b1;
		leaf[0].gap   = absdiff(tgt_s3, cur_s3);
		leaf[0].freq  = cur_s3;
		for (int d = 0; d < N_IN; d++) begin
			for (int i = 0; i < 2; i++) begin
				for (int e = 0; e < 2; e++) begin
					leaf[1+d*4+i*2+e].valid = fv_s3[d] && (i == 0 || two_s3) &&
						(e == 0 || near_s3[d]);
					leaf[1+d*4+i*2+e].improved = 1'b1;
					leaf[1+d*4+i*2+e].rng   = (i == 0) ? r0_s3 : r1_s3;
					leaf[1+d*4+i*2+e].freq  = (e == 0) ? prod_s3[d][i] :
						rng_ref((i == 0) ? r0_s3 : r1_s3);
					leaf[1+d*4+i*2+e].gap   = absdiff(leaf[1+d*4+i*2+e].freq, tgt_s3);
					leaf[1+d*4+i*2+e].src   = (d == 0) ? SRC_IRC : SRC_OSC0;
					leaf[1+d*4+i*2+e].div   = id_s3[d];
					leaf[1+d*4+i*2+e].exact = (e == 1);
				end
			end
		end
	end

	// Stages 4 and 5: closest-candidate search.
	cand_t win_s5;
	fcs_min_tree u_tree (
		.clk    (clk),
		.leaf   (leaf),
		.win_s5 (win_s5)
	);

	logic bad_s4, bad_s5;
	always_ff @(posedge clk) begin
		bad_s4 <= (cur_s3 == 32'd0);
		bad_s5 <= bad_s4;
	end

	// Result formatting.
	always_comb begin
		rsp = '0;
		if (bad_s5) begin
			rsp.bad_request = 1'b1;
		end else if (win_s5.improved) begin
			rsp.improved   = 1'b1;
			rsp.target_hit = (win_s5.gap == 32'd0);
			rsp.src_sel    = win_s5.src;
			rsp.div_sel    = win_s5.div;
			rsp.exact_sel  = win_s5.exact;
			rsp.rng_sel    = win_s5.rng;
			rsp.out_freq   = win_s5.freq;
		end
	end

	assign done = v_s5;

	// Every request gives one result and every result comes from a request.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done) else $error("request without result");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5)) else $error("result without request");
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.bad_request |-> !rsp.improved && rsp.out_freq == 32'd0)
		else $error("bad request carries data");
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.target_hit |-> rsp.improved && !rsp.bad_request)
		else $error("target hit without improvement");

endmodule

@@ sim/tb_fll_clock_config_search.sv @@
`timescale 1ns / 1ps

module tb_fll_clock_config_search;
	import fcs_pkg::*;

	localparam int LATENCY = 5;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        done;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = CFG_IRC;
	logic [31:0] cfg_wdata = '0;

	// Predictor copy of the configuration registers.
	logic [19:0] irc_hz;
	logic [31:0] osc0_hz;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   send_idle_pct = 0;
	int   quiet_cycles = 0;
	bit   failed = 1'b0;

	fll_clock_config_search uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] rng_mult(input logic [1:0] r);
		case (r)
			2'd0: return 32'd640;
			2'd1: return 32'd1280;
			2'd2: return 32'd1920;
			default: return 32'd2560;
		endcase
	endfunction

	function automatic logic [31:0] exact_out(input logic [1:0] r);
		case (r)
			2'd0: return 32'd24000000;
			2'd1: return 32'd48000000;
			2'd2: return 32'd72000000;
			default: return 32'd96000000;
		endcase
	endfunction

	function automatic logic [31:0] hi_divisor(input int k);
		case (k)
			0: return 32'd32;
			1: return 32'd64;
			2: return 32'd128;
			3: return 32'd256;
			4: return 32'd512;
			5: return 32'd1024;
			6: return 32'd1280;
			default: return 32'd1536;
		endcase
	endfunction

	function automatic logic [31:0] dist_of(input logic [31:0] a, input logic [31:0] b);
		return (a < b) ? (b - a) : (a - b);
	endfunction

	// Walk inputs and ranges for one source, keeping only strictly closer outputs.
	function automatic void search_source(inout rsp_t best, inout logic [31:0] best_dist,
			input logic [31:0] tgt, input logic [1:0] src,
			input logic [31:0] fin[2], input logic [2:0] fid[2], input int n_in,
			input logic [1:0] rl[2], input int n_r);
		logic [31:0] o;
		logic [31:0] d;
		for (int di = 0; di < n_in; di++) begin
			for (int ri = 0; ri < n_r; ri++) begin
				o = fin[di] * rng_mult(rl[ri]);
				d = dist_of(o, tgt);
				if (d < best_dist) begin
					best_dist = d;
					best = '{bad_request: 1'b0, improved: 1'b1, target_hit: 1'b0,
						src_sel: src, div_sel: fid[di], exact_sel: 1'b0,
						rng_sel: rl[ri], out_freq: o};
				end
				if (fin[di] < 32'd32770 && fin[di] > 32'd32766) begin
					o = exact_out(rl[ri]);
					d = dist_of(o, tgt);
					if (d < best_dist) begin
						best_dist = d;
						best = '{bad_request: 1'b0, improved: 1'b1, target_hit: 1'b0,
							src_sel: src, div_sel: fid[di], exact_sel: 1'b1,
							rng_sel: rl[ri], out_freq: o};
					end
				end
				if (best_dist == 0)
					return;
			end
		end
	endfunction

	function automatic rsp_t predict_config(input req_t r);
		rsp_t best;
		logic [31:0] best_dist;
		logic [1:0] rl[2];
		int n_r;
		logic [31:0] fin[2];
		logic [2:0] fid[2];
		int n_in;
		logic [31:0] v;
		logic [31:0] q;
		logic [31:0] rmin[4];
		logic [31:0] rmax[4];
		rmin = '{32'd20000000, 32'd40000000, 32'd60000000, 32'd80000000};
		rmax = '{32'd25000000, 32'd50000000, 32'd75000000, 32'd100000000};
		best = '0;
		if (r.current_freq == 0) begin
			best.bad_request = 1'b1;
			return best;
		end
		rl = '{2'd0, 2'd0};
		n_r = 0;
		// Range choice: one range inside or beyond the ends, two in a gap.
		if (r.target_freq <= rmin[0]) begin
			n_r = 1;
		end else if (r.target_freq >= rmax[3]) begin
			rl[0] = 2'd3;
			n_r = 1;
		end else begin
			for (int k = 0; k < 4 && n_r == 0; k++) begin
				if (r.target_freq < rmin[k]) begin
					rl[0] = 2'(k - 1);
					rl[1] = 2'(k);
					n_r = 2;
				end else if (r.target_freq <= rmax[k]) begin
					rl[0] = 2'(k);
					n_r = 1;
				end
			end
		end
		best_dist = dist_of(r.target_freq, r.current_freq);
		fin[0] = {12'd0, irc_hz};
		fid[0] = DIV_IRC;
		fin[1] = '0;
		fid[1] = '0;
		search_source(best, best_dist, r.target_freq, SRC_IRC, fin, fid, 1, rl, n_r);
		if (!(best.improved && best.out_freq == r.target_freq)) begin
			n_in = 0;
			// Oscillator 0 divider selection.
			if (osc0_hz < 32'd32786) begin
				v = osc0_hz;
				for (int k = 0; k < 8; k++) begin
					if (v < 32'd39062 && v > 32'd31250) begin
						fin[0] = v;
						fid[0] = 3'(k);
						n_in = 1;
						break;
					end
					v = v >> 1;
				end
			end else begin
				for (int k = 0; k < 8 && n_in < 2; k++) begin
					q = osc0_hz / hi_divisor(k);
					if (q <= 32'd39062 && q >= 32'd31250) begin
						fin[n_in] = q;
						fid[n_in] = 3'(k);
						n_in++;
					end
				end
			end
			if (n_in > 0)
				search_source(best, best_dist, r.target_freq, SRC_OSC0, fin, fid, n_in,
					rl, n_r);
		end
		if (best.improved)
			best.target_hit = (best.out_freq == r.target_freq);
		return best;
	endfunction

	// Request driver: issues pending requests with random gaps and records the predicted result of each accepted one.
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_rsps.push_back(predict_config(req));
		end
		if ((!start || !busy) && pending_reqs.size() > 0 &&
				$urandom_range(99, 0) >= send_idle_pct) begin
			start <= 1'b1;
			req <= pending_reqs.pop_front();
		end else if (!start || !busy) begin
			start <= 1'b0;
		end
	end

	// Result monitor with watchdog.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (done) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, rsp);
				failed = 1'b1;
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (rsp !== exp_rsp) begin
					$display("%0t: mismatch expected %p actual %p", $realtime, exp_rsp, rsp);
					failed = 1'b1;
				end
			end
		end
		if (done || (start && !busy))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic add_request(input logic [31:0] tgt, input logic [31:0] cur);
		req_t r;
		r.target_freq = tgt;
		r.current_freq = cur;
		pending_reqs.push_back(r);
	endtask

	// Wait for the pipeline to drain before touching the registers.
	task automatic drain();
		while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// One register write: enable raised on one edge, lowered on the next.
	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IRC)
			irc_hz = val[19:0];
		else
			osc0_hz = val;
	endtask

	function automatic logic [31:0] rand_target();
		case ($urandom_range(5, 0))
			0: return $urandom();
			1: return $urandom_range(110000000, 15000000);
			2: return 32'd24000000 + $urandom_range(4, 0) * 32'd24000000 - 2;
			3: return {irc_hz, 12'd0} >> $urandom_range(2, 0);
			default: return $urandom_range(105000000, 0);
		endcase
	endfunction

	function automatic logic [31:0] rand_osc();
		case ($urandom_range(4, 0))
			0: return $urandom();
			1: return $urandom_range(39100, 0) << $urandom_range(7, 0);
			2: return $urandom_range(39062, 31250) * hi_divisor($urandom_range(7, 0));
			3: return 32'd32768 << $urandom_range(10, 0);
			default: return $urandom_range(60000000, 1000000);
		endcase
	endfunction

	task automatic add_random_requests(input int n);
		logic [31:0] tgt;
		logic [31:0] cur;
		for (int i = 0; i < n; i++) begin
			tgt = rand_target();
			case ($urandom_range(9, 0))
				0: cur = 32'd0;
				1: cur = $urandom();
				2: cur = tgt;
				default: cur = tgt + $urandom_range(4000000, 0) - 32'd2000000;
			endcase
			add_request(tgt, cur);
		end
	endtask

	initial begin
		irc_hz = 20'd32768;
		osc0_hz = 32'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, zero current, range edges and gaps, ties.
		send_idle_pct = 36;
		add_request(32'd24000000, 32'd0);
		add_request(32'd0, 32'd1);
		add_request(32'hFFFFFFFF, 32'hFFFFFFFF);
		add_request(32'd20000000, 32'd1);
		add_request(32'd100000000, 32'd1);
		add_request(32'd30000000, 32'd1);
		add_request(32'd55000000, 32'd1);
		add_request(32'd78000000, 32'd1);
		add_request(32'd24000000, 32'd24000000);
		add_request(32'd20971520, 32'd20971519);
		add_request(32'd96000000, 32'hFFFFFFFF);
		drain();

		// High divider path with one match, low-split halving path, then no divider match.
		write_reg(CFG_OSC0, 32'd8000000);
		write_reg(CFG_IRC, 32'd0);
		add_request(32'd22000000, 32'd1);
		add_request(32'd45000000, 32'd1);
		add_request(32'd47900000, 32'd5);
		add_request(32'd0, 32'hFFFFFFFF);
		drain();
		write_reg(CFG_OSC0, 32'd32785);
		write_reg(CFG_IRC, 32'hFFFFF);
		add_request(32'd24000000, 32'd1);
		add_request(32'hFFFFFFFF, 32'd1);
		drain();
		write_reg(CFG_OSC0, 32'hFFFFFFFF);
		write_reg(CFG_IRC, 32'd32767);
		add_request(32'd24000000, 32'd7);
		add_request(32'd85000000, 32'd7);
		drain();

		// Random phases with changing configuration and idling patterns.
		for (int ph = 0; ph < 9; ph++) begin
			send_idle_pct = (ph < 3) ? 36 : (ph < 6) ? 64 : 0;
			write_reg(CFG_OSC0, rand_osc());
			write_reg(CFG_IRC, ($urandom_range(1, 0) == 1) ?
				32'd32766 + $urandom_range(4, 0) : $urandom_range(1000000, 0));
			add_random_requests(100);
			drain();
		end

		if (!failed)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
